[sv/sorted_table_binary_search_assert.svh]
// Assertion macros for the sorted-table binary search block.
// Included by the top level; define ASSERT_OFF to compile the checks out.
`ifndef SORTED_TABLE_BINARY_SEARCH_ASSERT_SVH
`define SORTED_TABLE_BINARY_SEARCH_ASSERT_SVH

`ifndef ASSERT_OFF

// Implication checked on every rising edge, held off while reset is low.
`define SBS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Implication checked on every rising edge, reset included.
`define SBS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) \
        else $error(msg);

`else

`define SBS_ASSERT(lbl, prop, msg)
`define SBS_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

[sv/sbs_pkg.sv]
// Shared types and constants for the sorted-table binary search block.
// No dependencies; used by every module of the block.
package sbs_pkg;

    localparam int IDX_W  = 10;
    localparam int DATA_W = 32;
    localparam int SIZE_W = 11;

    // Operation codes of a request.
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_PROBE
    } t_sbs_state;

    typedef struct packed {
        logic                     operation;
        logic [IDX_W-1:0]         entry_index;
        logic signed [DATA_W-1:0] data_value;
    } t_sbs_req;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] match_index;
    } t_sbs_rsp;

    // Status from the search controller to the top level.
    typedef struct packed {
        logic busy;
        logic result_valid;
    } t_sbs_status;

endpackage

[sv/sbs_table_ram.sv]
// Single-port-write, single-port-read table memory with registered read data.
// Depends on sbs_pkg for the entry width.
module sbs_table_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                             i_clk,
    input  logic                             i_wr_en,
    input  logic [AW-1:0]                    i_wr_addr,
    input  logic signed [sbs_pkg::DATA_W-1:0] i_wr_data,
    input  logic                             i_rd_en,
    input  logic [AW-1:0]                    i_rd_addr,
    output logic signed [sbs_pkg::DATA_W-1:0] o_rd_data
);

    logic signed [sbs_pkg::DATA_W-1:0] mem [DEPTH];
    logic signed [sbs_pkg::DATA_W-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[sv/sbs_search_ctrl.sv]
// Request handling and probe sequencer for the binary search.
// Depends on sbs_pkg; drives the ports of sbs_table_ram.
module sbs_search_ctrl #(
    parameter int TABLE_DEPTH = 1024,
    parameter int AW          = 10,
    parameter int CW          = 11
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  sbs_pkg::t_sbs_req                 i_request,
    input  logic [CW-1:0]                     i_size,
    output sbs_pkg::t_sbs_status              o_status,
    output sbs_pkg::t_sbs_rsp                 o_result,
    output logic                              o_wr_en,
    output logic [AW-1:0]                     o_wr_addr,
    output logic signed [sbs_pkg::DATA_W-1:0] o_wr_data,
    output logic                              o_rd_en,
    output logic [AW-1:0]                     o_rd_addr,
    input  logic signed [sbs_pkg::DATA_W-1:0] i_rd_data
);

    sbs_pkg::t_sbs_state               r_state, n_state;
    logic [CW-1:0]                     r_left, n_left;
    logic [CW-1:0]                     r_hi, n_hi;
    logic [AW-1:0]                     r_mid, n_mid;
    logic signed [sbs_pkg::DATA_W-1:0] r_key, n_key;
    logic                              r_strobe, n_strobe;
    logic                              r_found, n_found;
    logic [sbs_pkg::IDX_W-1:0]         r_index, n_index;

    logic [CW-1:0] mid_c;
    logic [CW-1:0] sum_first;
    logic [CW-1:0] sum_upper;
    logic [CW-1:0] sum_lower;
    logic [CW-1:0] left_inc;
    logic [31:0]   mid_ext;
    logic [31:0]   wr_idx_ext;
    logic          wr_in_range;

    // Midpoint candidates: the first probe, and the two halves after a miss.
    // Here hi is one past the right bound, so mid = (left + hi - 1) / 2.
    always_comb begin
        mid_c     = {1'b0, r_mid};
        sum_first = i_size - CW'(1);
        left_inc  = mid_c + CW'(1);
        sum_upper = mid_c + r_hi;
        sum_lower = r_left + mid_c - CW'(1);
        mid_ext   = 32'(r_mid);
    end

    // Write address and range check.
    assign wr_idx_ext  = 32'(i_request.entry_index);
    assign wr_in_range = (wr_idx_ext < 32'(TABLE_DEPTH));

    // Next state, memory ports and result.
    always_comb begin
        n_state   = r_state;
        n_left    = r_left;
        n_hi      = r_hi;
        n_mid     = r_mid;
        n_key     = r_key;
        n_strobe  = 1'b0;
        n_found   = r_found;
        n_index   = r_index;
        o_wr_en   = 1'b0;
        o_wr_addr = wr_idx_ext[AW-1:0];
        o_wr_data = i_request.data_value;
        o_rd_en   = 1'b0;
        o_rd_addr = '0;

        unique case (r_state)
            sbs_pkg::ST_IDLE: begin
                if (i_start) begin
                    if (i_request.operation == sbs_pkg::OP_WRITE) begin
                        o_wr_en = wr_in_range;
                    end else begin
                        n_key  = i_request.data_value;
                        n_left = '0;
                        n_hi   = i_size;
                        if (i_size == '0) begin
                            // Empty table: answer not found at once.
                            n_strobe = 1'b1;
                            n_found  = 1'b0;
                            n_index  = '0;
                        end else begin
                            o_rd_en   = 1'b1;
                            o_rd_addr = sum_first[AW:1];
                            n_mid     = sum_first[AW:1];
                            n_state   = sbs_pkg::ST_PROBE;
                        end
                    end
                end
            end

            sbs_pkg::ST_PROBE: begin
                if (i_rd_data == r_key) begin
                    n_strobe = 1'b1;
                    n_found  = 1'b1;
                    n_index  = mid_ext[sbs_pkg::IDX_W-1:0];
                    n_state  = sbs_pkg::ST_IDLE;
                end else if (i_rd_data < r_key) begin
                    // Entry below the key: continue in the upper half.
                    n_left = left_inc;
                    if (left_inc >= r_hi) begin
                        n_strobe = 1'b1;
                        n_found  = 1'b0;
                        n_index  = '0;
                        n_state  = sbs_pkg::ST_IDLE;
                    end else begin
                        o_rd_en   = 1'b1;
                        o_rd_addr = sum_upper[AW:1];
                        n_mid     = sum_upper[AW:1];
                    end
                end else begin
                    // Entry above the key: continue in the lower half.
                    n_hi = mid_c;
                    if (r_left >= mid_c) begin
                        n_strobe = 1'b1;
                        n_found  = 1'b0;
                        n_index  = '0;
                        n_state  = sbs_pkg::ST_IDLE;
                    end else begin
                        o_rd_en   = 1'b1;
                        o_rd_addr = sum_lower[AW:1];
                        n_mid     = sum_lower[AW:1];
                    end
                end
            end

            default: begin
                n_state = sbs_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sbs_pkg::ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    // Search bounds, key and result payload.
    always_ff @(posedge i_clk) begin
        r_left  <= n_left;
        r_hi    <= n_hi;
        r_mid   <= n_mid;
        r_key   <= n_key;
        r_found <= n_found;
        r_index <= n_index;
    end

    assign o_status.busy         = (r_state != sbs_pkg::ST_IDLE);
    assign o_status.result_valid = r_strobe;
    assign o_result.found        = r_found;
    assign o_result.match_index  = r_index;

endmodule

[sv/sorted_table_binary_search.sv]
// Sorted-table binary search: a write request stores one signed 32-bit entry
// in the table memory; a search of a non-empty table keeps busy high and probes
// the memory once per cycle at the midpoint of the remaining range, a rate set
// by the single read port of the table memory. The result appears on o_result
// with o_result_strobe for exactly one cycle, the cycle in which busy falls; an
// empty table answers in the cycle after the request. Results cannot be held
// off: a receiver must take each strobe.
// Depends on sbs_pkg, sbs_table_ram, sbs_search_ctrl and the assertion header.
`include "sorted_table_binary_search_assert.svh"

module sorted_table_binary_search #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  sbs_pkg::t_sbs_req           i_request,
    output logic                        o_result_strobe,
    output sbs_pkg::t_sbs_rsp           o_result,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [sbs_pkg::SIZE_W-1:0]  i_cfg_data
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = AW + 1;

    logic [sbs_pkg::SIZE_W-1:0]        r_table_size;
    logic [31:0]                       size_clamped;
    logic [CW-1:0]                     search_size;
    sbs_pkg::t_sbs_status              status;
    logic                              wr_en;
    logic [AW-1:0]                     wr_addr;
    logic signed [sbs_pkg::DATA_W-1:0] wr_data;
    logic                              rd_en;
    logic [AW-1:0]                     rd_addr;
    logic signed [sbs_pkg::DATA_W-1:0] rd_data;

    // Size register; writes are accepted in any cycle.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_table_size <= i_cfg_data;
        end
    end

    // A size above the table depth searches the whole table.
    assign size_clamped = (32'(r_table_size) > 32'(TABLE_DEPTH)) ?
                          32'(TABLE_DEPTH) : 32'(r_table_size);
    assign search_size  = size_clamped[CW-1:0];

    sbs_search_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW),
        .CW          (CW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_request (i_request),
        .i_size    (search_size),
        .o_status  (status),
        .o_result  (o_result),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data)
    );

    sbs_table_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign busy            = status.busy;
    assign o_result_strobe = status.result_valid;

    // A write request never produces a result.
    `SBS_ASSERT(a_write_no_result, start && !busy && (i_request.operation == sbs_pkg::OP_WRITE) |=> !o_result_strobe, "result strobe after a write request")
    // A search ends only by delivering its result.
    `SBS_ASSERT(a_busy_fall_result, $fell(busy) |-> o_result_strobe, "search ended without a result")
    // An empty table answers not found in the next cycle.
    `SBS_ASSERT(a_empty_not_found, start && !busy && (i_request.operation == sbs_pkg::OP_SEARCH) && (search_size == '0) |=> o_result_strobe && !o_result.found, "empty table search did not report not found")
    // A not-found result carries a zero index.
    `SBS_ASSERT_ALWAYS(a_miss_index_zero, i_rst_n && o_result_strobe && !o_result.found |-> (o_result.match_index == '0), "not-found result with nonzero index")

endmodule

[bench/sbs_search_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the sorted-table binary search block: mirrors the table and the size
// register from the accepted requests, predicts every search answer and compares it.
// Depends on sbs_pkg.
module sbs_search_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  sbs_pkg::t_sbs_req i_request,
    input  logic              i_result_strobe,
    input  sbs_pkg::t_sbs_rsp i_result,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [10:0]       i_cfg_data,
    output int                o_fail_count,
    output int                o_outstanding
);
    import sbs_pkg::*;

    localparam int DEPTH        = 1024;
    localparam int REPORT_LIMIT = 10;

    logic signed [DATA_W-1:0] table_mirror [0:DEPTH-1];
    logic [SIZE_W-1:0]        mirrored_size;
    t_sbs_rsp                 expected_answers [$];
    t_sbs_rsp                 want_rsp;
    int                       fail_count;

    // Binary search over the mirrored table, floor midpoint, signed compare.
    function automatic t_sbs_rsp predict_search(input logic signed [DATA_W-1:0] key);
        t_sbs_rsp rsp;
        int       lo;
        int       hi;
        int       mid;
        rsp = '0;
        lo  = 0;
        hi  = (mirrored_size > DEPTH) ? DEPTH - 1 : int'(mirrored_size) - 1;
        while (lo <= hi && !rsp.found) begin
            mid = (lo + hi) / 2;
            if (table_mirror[mid] == key) begin
                rsp.found       = 1'b1;
                rsp.match_index = mid[IDX_W-1:0];
            end else if (table_mirror[mid] < key) begin
                lo = mid + 1;
            end else begin
                hi = mid - 1;
            end
        end
        return rsp;
    endfunction

    // All observation happens on the rising edge, before the block's outputs move.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mirrored_size = '0;
            expected_answers.delete();
        end else begin
            // Answers leave in request order, so the oldest prediction is the match.
            if (i_result_strobe) begin
                if (expected_answers.size() == 0) begin
                    if (fail_count < REPORT_LIMIT)
                        $display("%0t: unexpected answer found=%0b match_index=%0d",
                                 $realtime, i_result.found, i_result.match_index);
                    fail_count++;
                end else begin
                    want_rsp = expected_answers.pop_front();
                    if (i_result.found !== want_rsp.found
                            || i_result.match_index !== want_rsp.match_index) begin
                        if (fail_count < REPORT_LIMIT)
                            $display("%0t: answer mismatch found exp %0b got %0b, %s%0d got %0d",
                                     $realtime, want_rsp.found, i_result.found,
                                     "match_index exp ", want_rsp.match_index,
                                     i_result.match_index);
                        fail_count++;
                    end
                end
            end

            // A write updates the mirror, a search queues its predicted answer.
            if (i_start && !i_busy) begin
                if (i_request.operation == OP_WRITE)
                    table_mirror[i_request.entry_index] = i_request.data_value;
                else
                    expected_answers.push_back(predict_search(i_request.data_value));
            end

            if (i_cfg_valid && i_cfg_ready)
                mirrored_size = i_cfg_data;
        end
        o_fail_count  = fail_count;
        o_outstanding = expected_answers.size();
    end

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// Bench top for the sorted-table binary search block: clock, reset, table and size
// stimulus, and the verdict. Depends on sbs_pkg, the block and sbs_search_checker.
module tb;
    import sbs_pkg::*;

    localparam int DEPTH         = 1024;
    localparam int PERIOD_NS     = 8;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int RANDOM_ITEMS  = 1900;
    localparam int SETTLE_CYCLES = 16;
    localparam logic signed [DATA_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] KEY_MAX = 32'sh7fff_ffff;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              start       = 1'b0;
    logic              busy;
    t_sbs_req          i_request   = '0;
    logic              o_result_strobe;
    t_sbs_rsp          o_result;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [SIZE_W-1:0] i_cfg_data  = '0;

    int fail_count;
    int outstanding;
    int cycle_count;
    int items_sent;
    bit steady;

    // Values written so far, used to aim search keys at real entries.
    logic signed [DATA_W-1:0] entry_shadow [0:DEPTH-1];

    sorted_table_binary_search #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_request      (i_request),
        .o_result_strobe(o_result_strobe),
        .o_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    sbs_search_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_request      (i_request),
        .i_result_strobe(o_result_strobe),
        .i_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_outstanding  (outstanding)
    );

    always #(PERIOD_NS / 2) i_clk = ~i_clk;

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("sorted_table_binary_search verification failed");
            $finish;
        end
    end

    // Presents one request from a falling edge and returns on the falling edge after it
    // was taken; start stays high so a following request goes out back to back.
    task automatic send_request(input logic op, input int idx,
                                input logic signed [DATA_W-1:0] value);
        t_sbs_req req;
        if (!steady && $urandom_range(0, 99) < 18) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        req.operation   = op;
        req.entry_index = idx[IDX_W-1:0];
        req.data_value  = value;
        start     <= 1'b1;
        i_request <= req;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic write_entry(input int idx, input logic signed [DATA_W-1:0] value);
        entry_shadow[idx] = value;
        send_request(OP_WRITE, idx, value);
    endtask

    task automatic search_key(input logic signed [DATA_W-1:0] key);
        send_request(OP_SEARCH, $urandom_range(0, DEPTH - 1), key);
    endtask

    // Holds requests back until every search answer has come out.
    task automatic wait_for_results();
        start <= 1'b0;
        @(negedge i_clk);
        while (outstanding != 0) @(negedge i_clk);
    endtask

    // Size writes only go out once the block is idle; a trailing table write has no
    // answer to wait for, so a few extra cycles cover it.
    task automatic write_size(input int value);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (!steady && $urandom_range(0, 99) < 18)
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value[SIZE_W-1:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Ascending fill of entries 0..count-1; a step of zero gives duplicates and the
    // top of the signed range saturates.
    task automatic fill_sorted(input int count, input int unsigned max_step,
                               input longint first);
        longint level;
        level = first;
        for (int i = 0; i < count; i++) begin
            if (level > 64'sd2147483647)
                level = 64'sd2147483647;
            write_entry(i, level[DATA_W-1:0]);
            level = level + longint'($urandom_range(0, max_step));
        end
    endtask

    // Mostly keys that sit in the searched range, else near misses and wild values.
    function automatic logic signed [DATA_W-1:0] pick_key(input int count);
        int sel;
        int at;
        sel = $urandom_range(0, 99);
        if (count == 0 || sel >= 85)
            return $urandom();
        at = $urandom_range(0, count - 1);
        if (sel < 60)
            return entry_shadow[at];
        if (sel < 72)
            return entry_shadow[at] + 1;
        if (sel < 80)
            return entry_shadow[at] - 1;
        return sel[0] ? KEY_MIN : KEY_MAX;
    endfunction

    // Sets the size, then searches with an occasional stray write that may unsort
    // the table and an occasional full drain of the answers.
    task automatic search_burst(input int size, input int count);
        int eff;
        write_size(size);
        eff = (size > DEPTH) ? DEPTH : size;
        repeat (count) begin
            if ($urandom_range(0, 49) == 0)
                wait_for_results();
            if ($urandom_range(0, 9) == 0)
                write_entry($urandom_range(0, DEPTH - 1), $urandom());
            else
                search_key(pick_key(eff));
        end
    endtask

    initial begin
        int n;
        int sel;
        steady = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Empty table after reset: a miss without any probe.
        search_key(32'sd0);

        // Short sorted table holding both ends of the signed range.
        write_entry(0, KEY_MIN);
        write_entry(1, -32'sd1000);
        write_entry(2, -32'sd1);
        write_entry(3, 32'sd0);
        write_entry(4, 32'sd1);
        write_entry(5, 32'sd1000);
        write_entry(6, KEY_MAX);
        write_entry(DEPTH - 1, 32'sh5a5a_a5a5);
        write_size(7);
        search_key(KEY_MIN);
        search_key(KEY_MAX);
        search_key(32'sd0);
        search_key(-32'sd1);
        search_key(32'sd1000);
        search_key(32'sd2);
        search_key(KEY_MIN + 1);

        // Single entry.
        write_size(1);
        search_key(KEY_MIN);
        search_key(KEY_MAX);

        // Unsorted table: the probe order stays the same and hits what it hits.
        write_entry(3, KEY_MAX);
        write_size(7);
        search_key(KEY_MAX);
        search_key(32'sd1);

        // Whole table filled once, so every size is legal from here on.
        items_sent = 0;
        fill_sorted(DEPTH, 32'h0040_0000, KEY_MIN);
        search_burst(DEPTH, 40);
        search_burst(2047, 40);
        search_burst(DEPTH - 1, 30);

        // Phases of small sorted tables with random content, some odd sizes between.
        while (items_sent < RANDOM_ITEMS) begin
            steady = (items_sent >= 1250 && items_sent < 1550);
            sel = $urandom_range(0, 99);
            if (sel < 75) begin
                n = $urandom_range(1, 24);
                fill_sorted(n, 1 << $urandom_range(0, 31), $signed($urandom()));
            end else if (sel < 85) begin
                n = 0;
            end else begin
                case ($urandom_range(0, 4))
                    0:       n = 1;
                    1:       n = 2;
                    2:       n = DEPTH;
                    3:       n = 2047;
                    default: n = $urandom_range(0, 2047);
                endcase
            end
            search_burst(n, $urandom_range(4, 16));
        end
        steady = 1'b0;

        wait_for_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && outstanding == 0)
            $display("sorted_table_binary_search verification clean");
        else
            $display("sorted_table_binary_search verification failed");
        $finish;
    end

endmodule
